// File: rtl/sscr_pkg.sv
// Shared constants, types and arithmetic helpers of the sphere collision response pipeline.
package sscr_pkg;

    // Number format of one vector component.
    localparam int COMP_BITS = 21;
    localparam int FRAC_BITS = 10;
    localparam int RAD_BITS  = COMP_BITS - 1;
    localparam int VEC_BITS  = 3 * COMP_BITS;
    localparam int SCL_BITS  = 16;
    localparam int TIM_BITS  = 16;
    localparam int GRV_BITS  = 16;

    // Fraction bits of the contact normal and of the fixed product formats.
    localparam int NORM_BITS = 16;
    localparam int GRAV_SH   = 26 - FRAC_BITS;
    localparam int RAD_SH    = 12;
    localparam int ADV_SH    = TIM_BITS;
    localparam int EPS_RAW   = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [GRV_BITS-1:0] GRAV_RESET = 16'd10035;

    // Internal widths.
    localparam int DV_W   = GRV_BITS + TIM_BITS - GRAV_SH + 1;
    localparam int RW_W   = RAD_BITS + SCL_BITS - RAD_SH + 1;
    localparam int R_W    = RW_W + 1;
    localparam int PEN_W  = R_W + 1;
    localparam int PR_W   = COMP_BITS + TIM_BITS + 1;
    localparam int D_W    = COMP_BITS + 2;
    localparam int SQ_W   = 2 * D_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int QB     = NORM_BITS + 2;
    localparam int DREM_W = ROOT_W + 1;
    localparam int NUM_W  = D_W - 1 + NORM_BITS + 1;
    localparam int N_W    = NORM_BITS + 2;
    localparam int PD_W   = COMP_BITS + N_W;
    localparam int REL_W  = PD_W + 2;
    localparam int PMV_W  = N_W + REL_W;
    localparam int PMP_W  = N_W + PEN_W;

    // Stage map of the pipeline.
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SQRT_PER_ST = 2;
    localparam int SQRT_STAGES = SQRT_STEPS / SQRT_PER_ST;
    localparam int DIV_PER_ST  = 3;
    localparam int DIV_STAGES  = QB / DIV_PER_ST;
    localparam int ST_CAP   = 0;
    localparam int ST_GRAV  = 1;
    localparam int ST_VADJ  = 2;
    localparam int ST_VMUL  = 3;
    localparam int ST_ADV   = 4;
    localparam int ST_DIFF  = 5;
    localparam int ST_SQR   = 6;
    localparam int ST_SUM   = 7;
    localparam int ST_SQRT0 = 8;
    localparam int ST_DPREP = ST_SQRT0 + SQRT_STAGES;
    localparam int ST_DIV0  = ST_DPREP + 1;
    localparam int ST_NRM   = ST_DIV0 + DIV_STAGES;
    localparam int ST_DOT   = ST_NRM + 1;
    localparam int ST_DSUM  = ST_DOT + 1;
    localparam int ST_RMUL  = ST_DSUM + 1;
    localparam int ST_FIN   = ST_RMUL + 1;
    localparam int N_STAGES = ST_FIN + 1;

    // Stream word layouts.
    localparam int IN_W  = 472;
    localparam int OUT_W = 256;
    localparam int IO_PA = 0;
    localparam int IO_VA = IO_PA + VEC_BITS;
    localparam int IO_OA = IO_VA + VEC_BITS;
    localparam int IO_RA = IO_OA + VEC_BITS;
    localparam int IO_SA = IO_RA + RAD_BITS;
    localparam int IO_PB = IO_SA + SCL_BITS;
    localparam int IO_VB = IO_PB + VEC_BITS;
    localparam int IO_OB = IO_VB + VEC_BITS;
    localparam int IO_RB = IO_OB + VEC_BITS;
    localparam int IO_SB = IO_RB + RAD_BITS;
    localparam int IO_T  = IO_SB + SCL_BITS;
    localparam int OO_OUTC = 4 * VEC_BITS;
    localparam int OO_SAT  = OO_OUTC + 2;

    // Outcome codes.
    localparam logic [1:0] OUT_NONE = 2'd0;
    localparam logic [1:0] OUT_SEP  = 2'd1;
    localparam logic [1:0] OUT_HIT  = 2'd2;

    localparam logic signed [63:0] CMAX = (64'sd1 <<< (COMP_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

    typedef logic [2:0][COMP_BITS-1:0] t_vec;

    // Everything one pair carries down the pipeline.
    typedef struct packed {
        t_vec                    pa;
        t_vec                    pb;
        t_vec                    va0;
        t_vec                    vb0;
        t_vec                    va;
        t_vec                    vb;
        t_vec                    oa;
        t_vec                    ob;
        logic [TIM_BITS-1:0]     t;
        logic [RAD_BITS-1:0]     rad_a;
        logic [RAD_BITS-1:0]     rad_b;
        logic [SCL_BITS-1:0]     sc_a;
        logic [SCL_BITS-1:0]     sc_b;
        logic [DV_W-1:0]         dv;
        logic [RW_W-1:0]         ra;
        logic [RW_W-1:0]         rb;
        logic [R_W-1:0]          r;
        logic [2:0][PR_W-1:0]    pra;
        logic [2:0][PR_W-1:0]    prb;
        logic [2:0][D_W-1:0]     d;
        logic [2:0][SQ_W-1:0]    sq;
        logic [SUM_W-1:0]        sum;
        logic [SREM_W-1:0]       srem;
        logic [ROOT_W-1:0]       root;
        logic [ROOT_W-1:0]       s;
        logic                    ovl;
        logic [PEN_W-1:0]        pen;
        logic [2:0]              dneg;
        logic [2:0][DREM_W-1:0]  drem;
        logic [2:0][QB-1:0]      dq;
        logic [2:0][N_W-1:0]     n;
        logic [2:0][PD_W-1:0]    pda;
        logic [2:0][PD_W-1:0]    pdb;
        logic [REL_W-1:0]        rel;
        logic [2:0][PMV_W-1:0]   pmv;
        logic [2:0][PMP_W-1:0]   pmp;
        logic [1:0]              outcome;
        logic                    sat;
    } t_item;

    // Shift right by sh bits, rounding to nearest with ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Clamp to the component range; the top bit flags a clamp.
    function automatic logic [COMP_BITS:0] clamp_comp(input logic signed [63:0] v);
        if (v > CMAX) begin
            return {1'b1, CMAX[COMP_BITS-1:0]};
        end
        if (v < CMIN) begin
            return {1'b1, CMIN[COMP_BITS-1:0]};
        end
        return {1'b0, v[COMP_BITS-1:0]};
    endfunction

endpackage

// File: rtl/sphere_sphere_collision_response_top.sv
// Top level of the sphere pair collision response pipeline.
// A word passes through 32 register stages from input to output; the square root
// takes 12 of them and the normal divider 6.
// Throughput: one word per cycle; each stage holds while its successor is full and stalled.
// Reset (i_rst_n low, synchronous) empties every stage and restores gravity to 9.8.
module sphere_sphere_collision_response_top
    import sscr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [GRV_BITS-1:0] i_cfg_wr_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // pos_a, vel_a, offset_a, radius_a, scale_a, pos_b, vel_b, offset_b, radius_b,
    // scale_b, impact_time, zero fill
    input  logic [IN_W-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // new_pos_a, new_vel_a, new_pos_b, new_vel_b, outcome, saturated, zero fill
    output logic [OUT_W-1:0]  o_m_tdata
);

    logic [GRV_BITS-1:0] r_gravity;
    t_item               r_pipe [N_STAGES];
    t_item               n_pipe [N_STAGES];
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_rdy;

    // Split an input word into its fields.
    function automatic t_item capture(input logic [IN_W-1:0] w);
        t_item b;
        b       = '0;
        b.pa    = w[IO_PA +: VEC_BITS];
        b.va0   = w[IO_VA +: VEC_BITS];
        b.oa    = w[IO_OA +: VEC_BITS];
        b.rad_a = w[IO_RA +: RAD_BITS];
        b.sc_a  = w[IO_SA +: SCL_BITS];
        b.pb    = w[IO_PB +: VEC_BITS];
        b.vb0   = w[IO_VB +: VEC_BITS];
        b.ob    = w[IO_OB +: VEC_BITS];
        b.rad_b = w[IO_RB +: RAD_BITS];
        b.sc_b  = w[IO_SB +: SCL_BITS];
        b.t     = w[IO_T +: TIM_BITS];
        b.va    = b.va0;
        b.vb    = b.vb0;
        return b;
    endfunction

    // Work of one pipeline stage, selected by its position.
    function automatic t_item step(input int k, input t_item a, input logic [GRV_BITS-1:0] g);
        t_item               b;
        logic [31:0]         w;
        logic [COMP_BITS:0]  c;
        logic [SREM_W-1:0]   rem2;
        logic [SREM_W-1:0]   trial;
        logic [DREM_W-1:0]   drem2;
        logic [D_W-1:0]      mag;
        logic [NUM_W-1:0]    num;
        logic [QB-1:0]       q;
        logic signed [63:0]  push;
        logic signed [63:0]  dvn;
        b = a;
        if (k == ST_GRAV) begin
            // Velocity change from gravity and the two world radii.
            w    = 32'(g) * 32'(a.t);
            b.dv = DV_W'(rnd_shift(64'(w), GRAV_SH));
            b.ra = RW_W'(rnd_shift(64'(36'(a.rad_a) * 36'(a.sc_a)), RAD_SH));
            b.rb = RW_W'(rnd_shift(64'(36'(a.rad_b) * 36'(a.sc_b)), RAD_SH));
        end else if (k == ST_VADJ) begin
            c        = clamp_comp(64'($signed(a.va[1])) - 64'(a.dv));
            b.va[1]  = c[COMP_BITS-1:0];
            b.sat    = b.sat | c[COMP_BITS];
            c        = clamp_comp(64'($signed(a.vb[1])) - 64'(a.dv));
            b.vb[1]  = c[COMP_BITS-1:0];
            b.sat    = b.sat | c[COMP_BITS];
            b.r      = R_W'(a.ra) + R_W'(a.rb);
        end else if (k == ST_VMUL) begin
            for (int i = 0; i < 3; i++) begin
                b.pra[i] = $signed(a.va[i]) * $signed({1'b0, a.t});
                b.prb[i] = $signed(a.vb[i]) * $signed({1'b0, a.t});
            end
        end else if (k == ST_ADV) begin
            for (int i = 0; i < 3; i++) begin
                c       = clamp_comp(64'($signed(a.pa[i]))
                                     + rnd_shift(64'($signed(a.pra[i])), ADV_SH));
                b.pa[i] = c[COMP_BITS-1:0];
                b.sat   = b.sat | c[COMP_BITS];
                c       = clamp_comp(64'($signed(a.pb[i]))
                                     + rnd_shift(64'($signed(a.prb[i])), ADV_SH));
                b.pb[i] = c[COMP_BITS-1:0];
                b.sat   = b.sat | c[COMP_BITS];
            end
        end else if (k == ST_DIFF) begin
            for (int i = 0; i < 3; i++) begin
                b.d[i] = D_W'(64'($signed(a.pb[i])) + 64'($signed(a.ob[i]))
                              - 64'($signed(a.pa[i])) - 64'($signed(a.oa[i])));
            end
        end else if (k == ST_SQR) begin
            for (int i = 0; i < 3; i++) begin
                b.sq[i] = $signed(a.d[i]) * $signed(a.d[i]);
            end
        end else if (k == ST_SUM) begin
            b.sum  = SUM_W'(a.sq[0]) + SUM_W'(a.sq[1]) + SUM_W'(a.sq[2]);
            b.srem = '0;
            b.root = '0;
        end else if (k >= ST_SQRT0 && k < ST_DPREP) begin
            // Digit-by-digit square root, two result bits per stage.
            for (int j = 0; j < SQRT_PER_ST; j++) begin
                rem2  = {b.srem[SREM_W-3:0], b.sum[SUM_W-1 -: 2]};
                b.sum = b.sum << 2;
                trial = {b.root, 2'b01};
                if (rem2 >= trial) begin
                    b.srem = rem2 - trial;
                    b.root = {b.root[ROOT_W-2:0], 1'b1};
                end else begin
                    b.srem = rem2;
                    b.root = {b.root[ROOT_W-2:0], 1'b0};
                end
            end
        end else if (k == ST_DPREP) begin
            // Overlap test, penetration and the rounded dividends of the normal.
            b.s   = a.root;
            b.ovl = R_W'(a.root) < a.r;
            b.pen = PEN_W'(a.r) - PEN_W'(a.root) + PEN_W'(EPS_RAW);
            for (int i = 0; i < 3; i++) begin
                b.dneg[i] = a.d[i][D_W-1];
                mag       = a.d[i][D_W-1] ? D_W'(-a.d[i]) : a.d[i];
                num       = {mag, {NORM_BITS{1'b0}}} + NUM_W'(a.root >> 1);
                b.drem[i] = DREM_W'(num >> QB);
                b.dq[i]   = num[QB-1:0];
            end
        end else if (k >= ST_DIV0 && k < ST_NRM) begin
            // Restoring division by the distance, three quotient bits per stage.
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < DIV_PER_ST; j++) begin
                    drem2   = {b.drem[i][DREM_W-2:0], b.dq[i][QB-1]};
                    b.dq[i] = b.dq[i] << 1;
                    if (drem2 >= DREM_W'(a.s)) begin
                        b.drem[i]  = drem2 - DREM_W'(a.s);
                        b.dq[i][0] = 1'b1;
                    end else begin
                        b.drem[i] = drem2;
                    end
                end
            end
        end else if (k == ST_NRM) begin
            for (int i = 0; i < 3; i++) begin
                q = a.dq[i];
                if (a.s == '0) begin
                    b.n[i] = '0;
                end else begin
                    b.n[i] = a.dneg[i] ? N_W'(-q) : N_W'(q);
                end
            end
        end else if (k == ST_DOT) begin
            for (int i = 0; i < 3; i++) begin
                b.pda[i] = $signed(a.va[i]) * $signed(a.n[i]);
                b.pdb[i] = $signed(a.vb[i]) * $signed(a.n[i]);
            end
        end else if (k == ST_DSUM) begin
            // Relative normal speed equals the difference of the two normal speeds.
            b.rel = REL_W'($signed(a.pdb[0])) + REL_W'($signed(a.pdb[1]))
                  + REL_W'($signed(a.pdb[2])) - REL_W'($signed(a.pda[0]))
                  - REL_W'($signed(a.pda[1])) - REL_W'($signed(a.pda[2]));
        end else if (k == ST_RMUL) begin
            for (int i = 0; i < 3; i++) begin
                b.pmv[i] = $signed(a.n[i]) * $signed(a.rel);
                b.pmp[i] = $signed(a.n[i]) * $signed(a.pen);
            end
        end else if (k == ST_FIN) begin
            // Pick the result for the three cases and resolve an approaching pair.
            if (!a.ovl) begin
                b.outcome = OUT_NONE;
                b.va      = a.va0;
                b.vb      = a.vb0;
            end else if (a.rel[REL_W-1]) begin
                b.outcome = OUT_HIT;
                for (int i = 0; i < 3; i++) begin
                    push    = rnd_shift(64'($signed(a.pmp[i])), NORM_BITS + 1);
                    dvn     = rnd_shift(64'($signed(a.pmv[i])), 2 * NORM_BITS);
                    c       = clamp_comp(64'($signed(a.pb[i])) + push);
                    b.pb[i] = c[COMP_BITS-1:0];
                    b.sat   = b.sat | c[COMP_BITS];
                    c       = clamp_comp(64'($signed(a.pa[i])) - push);
                    b.pa[i] = c[COMP_BITS-1:0];
                    b.sat   = b.sat | c[COMP_BITS];
                    c       = clamp_comp(64'($signed(a.va[i])) + dvn);
                    b.va[i] = c[COMP_BITS-1:0];
                    b.sat   = b.sat | c[COMP_BITS];
                    c       = clamp_comp(64'($signed(a.vb[i])) - dvn);
                    b.vb[i] = c[COMP_BITS-1:0];
                    b.sat   = b.sat | c[COMP_BITS];
                end
            end else begin
                b.outcome = OUT_SEP;
            end
        end
        return b;
    endfunction

    // Gravity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAV_RESET;
        end else if (i_cfg_wr_en) begin
            r_gravity <= i_cfg_wr_data;
        end
    end

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        w_rdy[N_STAGES-1] = !r_vld[N_STAGES-1] || i_m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Next value of every stage.
    always_comb begin
        n_pipe[ST_CAP] = capture(i_s_tdata);
        for (int k = 1; k < N_STAGES; k++) begin
            n_pipe[k] = step(k, r_pipe[k-1], r_gravity);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[ST_CAP]) begin
                r_vld[ST_CAP] <= i_s_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_s_tready = w_rdy[ST_CAP];
    assign o_m_tvalid = r_vld[N_STAGES-1];
    assign o_m_tdata  = {1'b0, r_pipe[N_STAGES-1].sat, r_pipe[N_STAGES-1].outcome,
                         r_pipe[N_STAGES-1].vb, r_pipe[N_STAGES-1].pb,
                         r_pipe[N_STAGES-1].va, r_pipe[N_STAGES-1].pa};

endmodule

// File: rtl/sscr_checker.sv
// Port-level checks of the collision response top level, bound to it.
module sscr_checker
    import sscr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // A waiting result word stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word withdrawn while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word offered after reset");

    // With the output side free, every stage can move, so input is taken.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output side is free");

    // Only the three defined outcomes appear.
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OO_OUTC +: 2] == OUT_NONE
                        || o_m_tdata[OO_OUTC +: 2] == OUT_SEP
                        || o_m_tdata[OO_OUTC +: 2] == OUT_HIT))
        else $error("undefined outcome code");

endmodule

bind sphere_sphere_collision_response_top sscr_checker u_sscr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: tb/tb_sphere_sphere_collision_response_top.sv
// Testbench for the sphere pair collision response pipeline, checked against a local predictor.
module tb_sphere_sphere_collision_response_top
    import sscr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    // One body pair as it enters the block.
    typedef struct {
        t_vec                pa, va, oa, pb, vb, ob;
        logic [RAD_BITS-1:0] ra, rb;
        logic [SCL_BITS-1:0] sa, sb;
        logic [TIM_BITS-1:0] t;
    } t_pair;

    // One response word as it leaves the block.
    typedef struct {
        t_vec       npa, nva, npb, nvb;
        logic [1:0] outcome;
        logic       sat;
    } t_resp;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [GRV_BITS-1:0] i_cfg_wr_data;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;

    t_resp               pending_resp[$];
    logic [GRV_BITS-1:0] gravity_model;
    int                  fail_count = 0;
    int                  cycle_count = 0;
    bit                  hold_req;
    bit                  steady_send;
    bit                  steady_recv;

    sphere_sphere_collision_response_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // Clock with a 12 ns period.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    // Shift right rounding to nearest, ties away from zero.
    function automatic longint round_shift(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Division rounding to nearest, ties away from zero.
    function automatic longint round_div(longint num, longint den);
        longint unsigned m;
        m = (num < 0) ? longint'(-num) : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Floor square root, two bits per step.
    function automatic longint floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // Limit to the component range and note any clamp.
    function automatic longint clamp_component(longint v, inout bit hit);
        if (v > CMAX) begin
            hit = 1'b1;
            return CMAX;
        end
        if (v < CMIN) begin
            hit = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    // Full collision response for one pair under the given gravity.
    function automatic t_resp predict_response(t_pair p, logic [GRV_BITS-1:0] g);
        longint pa[3], pb[3], va[3], vb[3], oa[3], ob[3], va0[3], vb0[3], d[3], n[3];
        longint t, dv, ra, rb, r, s, pen, rel, vda, vdb, push, dvn;
        longint unsigned sum;
        bit     hit;
        t_resp  res;
        hit = 1'b0;
        sum = 0;
        t   = longint'(p.t);
        for (int i = 0; i < 3; i++) begin
            pa[i]  = longint'($signed(p.pa[i]));
            pb[i]  = longint'($signed(p.pb[i]));
            va0[i] = longint'($signed(p.va[i]));
            vb0[i] = longint'($signed(p.vb[i]));
            oa[i]  = longint'($signed(p.oa[i]));
            ob[i]  = longint'($signed(p.ob[i]));
            va[i]  = va0[i];
            vb[i]  = vb0[i];
        end
        // Gravity acts on the vertical velocity up to the hit time.
        dv    = round_shift(longint'(g) * t, 26 - FRAC_BITS);
        va[1] = clamp_component(va[1] - dv, hit);
        vb[1] = clamp_component(vb[1] - dv, hit);
        for (int i = 0; i < 3; i++) begin
            pa[i] = clamp_component(pa[i] + round_shift(va[i] * t, 16), hit);
            pb[i] = clamp_component(pb[i] + round_shift(vb[i] * t, 16), hit);
        end
        ra = round_shift(longint'(p.ra) * longint'(p.sa), 12);
        rb = round_shift(longint'(p.rb) * longint'(p.sb), 12);
        r  = ra + rb;
        for (int i = 0; i < 3; i++) begin
            d[i] = (pb[i] + ob[i]) - (pa[i] + oa[i]);
            sum  = sum + longint'(d[i] * d[i]);
        end
        s = floor_sqrt(sum);
        if (!(s < r)) begin
            res.outcome = OUT_NONE;
            for (int i = 0; i < 3; i++) begin
                va[i] = va0[i];
                vb[i] = vb0[i];
            end
        end else begin
            pen = r - s + EPS_RAW;
            for (int i = 0; i < 3; i++) begin
                n[i] = (s > 0) ? round_div(d[i] * (64'sd1 <<< NORM_BITS), s) : 0;
            end
            rel = 0;
            vda = 0;
            vdb = 0;
            for (int i = 0; i < 3; i++) begin
                rel = rel + (vb[i] - va[i]) * n[i];
                vda = vda + va[i] * n[i];
                vdb = vdb + vb[i] * n[i];
            end
            if (rel < 0) begin
                // Approaching: push apart and exchange normal speeds.
                res.outcome = OUT_HIT;
                for (int i = 0; i < 3; i++) begin
                    push  = round_shift(n[i] * pen, NORM_BITS + 1);
                    dvn   = round_shift(n[i] * (vdb - vda), 2 * NORM_BITS);
                    pb[i] = clamp_component(pb[i] + push, hit);
                    pa[i] = clamp_component(pa[i] - push, hit);
                    va[i] = clamp_component(va[i] + dvn, hit);
                    vb[i] = clamp_component(vb[i] - dvn, hit);
                end
            end else begin
                res.outcome = OUT_SEP;
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.npa[i] = pa[i][COMP_BITS-1:0];
            res.nva[i] = va[i][COMP_BITS-1:0];
            res.npb[i] = pb[i][COMP_BITS-1:0];
            res.nvb[i] = vb[i][COMP_BITS-1:0];
        end
        res.sat = hit;
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [COMP_BITS-1:0] rand_comp(int span);
        return COMP_BITS'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_vec rand_vec(int span);
        t_vec v;
        for (int i = 0; i < 3; i++) v[i] = rand_comp(span);
        return v;
    endfunction

    // Any bit pattern in every field.
    function automatic t_pair noise_pair();
        t_pair p;
        p.pa = VEC_BITS'({$urandom(), $urandom()});
        p.va = VEC_BITS'({$urandom(), $urandom()});
        p.oa = VEC_BITS'({$urandom(), $urandom()});
        p.pb = VEC_BITS'({$urandom(), $urandom()});
        p.vb = VEC_BITS'({$urandom(), $urandom()});
        p.ob = VEC_BITS'({$urandom(), $urandom()});
        p.ra = RAD_BITS'($urandom());
        p.rb = RAD_BITS'($urandom());
        p.sa = SCL_BITS'($urandom());
        p.sb = SCL_BITS'($urandom());
        p.t  = TIM_BITS'($urandom());
        return p;
    endfunction

    // Two spheres near each other so that contacts are frequent.
    function automatic t_pair near_pair();
        t_pair p;
        p.pa = rand_vec(16384);
        for (int i = 0; i < 3; i++) p.pb[i] = p.pa[i] + rand_comp(2048);
        p.va = rand_vec(8192);
        p.vb = rand_vec(8192);
        p.oa = rand_vec(256);
        p.ob = rand_vec(256);
        p.ra = RAD_BITS'($urandom_range(0, 2048));
        p.rb = RAD_BITS'($urandom_range(0, 2048));
        p.sa = SCL_BITS'($urandom_range(1024, 8192));
        p.sb = SCL_BITS'($urandom_range(1024, 8192));
        p.t  = TIM_BITS'($urandom());
        return p;
    endfunction

    function automatic t_pair mixed_pair();
        return ($urandom_range(0, 99) < 85) ? near_pair() : noise_pair();
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Drive one word on the input and hold it until it is taken.
    task automatic send_pair(t_pair p);
        int gap;
        gap = steady_send ? 0 : gap_cycles();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = '0;
        i_s_tdata[IO_PA +: VEC_BITS] = p.pa;
        i_s_tdata[IO_VA +: VEC_BITS] = p.va;
        i_s_tdata[IO_OA +: VEC_BITS] = p.oa;
        i_s_tdata[IO_RA +: RAD_BITS] = p.ra;
        i_s_tdata[IO_SA +: SCL_BITS] = p.sa;
        i_s_tdata[IO_PB +: VEC_BITS] = p.pb;
        i_s_tdata[IO_VB +: VEC_BITS] = p.vb;
        i_s_tdata[IO_OB +: VEC_BITS] = p.ob;
        i_s_tdata[IO_RB +: RAD_BITS] = p.rb;
        i_s_tdata[IO_SB +: SCL_BITS] = p.sb;
        i_s_tdata[IO_T  +: TIM_BITS] = p.t;
        do @(posedge i_clk); while (!o_s_tready);
        pending_resp.push_back(predict_response(p, gravity_model));
    endtask

    // Lower valid and wait until every response is back and the pipeline is empty.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (pending_resp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gravity(logic [GRV_BITS-1:0] g);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = g;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        gravity_model = g;
    endtask

    // ---------------------------------------------------------------- output side

    // Ready pattern: steady, random short and long stalls, or a counted hold-off.
    initial begin
        int stall_left;
        int hold_left;
        bit hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            // A new hold request starts a hold-off that keeps ready low.
            if (hold_req && !hold_seen) begin
                hold_left = HOLD_CYCLES;
            end
            hold_seen = hold_req;
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                i_m_tready = 1'b0;
            end else if (steady_recv) begin
                i_m_tready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_tready = 1'b0;
            end else begin
                stall_left = gap_cycles();
                i_m_tready = (stall_left == 0);
                if (stall_left > 0) stall_left = stall_left - 1;
            end
        end
    end

    // Compare each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        t_resp want;
        t_resp got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.npa     = o_m_tdata[0 +: VEC_BITS];
            got.nva     = o_m_tdata[VEC_BITS +: VEC_BITS];
            got.npb     = o_m_tdata[2 * VEC_BITS +: VEC_BITS];
            got.nvb     = o_m_tdata[3 * VEC_BITS +: VEC_BITS];
            got.outcome = o_m_tdata[OO_OUTC +: 2];
            got.sat     = o_m_tdata[OO_SAT];
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_m_tdata);
                fail_count = fail_count + 1;
            end else begin
                want = pending_resp.pop_front();
                if (got.npa !== want.npa) begin
                    $display("%0t: new_pos_a expected %h actual %h", $time, want.npa, got.npa);
                    fail_count = fail_count + 1;
                end
                if (got.nva !== want.nva) begin
                    $display("%0t: new_vel_a expected %h actual %h", $time, want.nva, got.nva);
                    fail_count = fail_count + 1;
                end
                if (got.npb !== want.npb) begin
                    $display("%0t: new_pos_b expected %h actual %h", $time, want.npb, got.npb);
                    fail_count = fail_count + 1;
                end
                if (got.nvb !== want.nvb) begin
                    $display("%0t: new_vel_b expected %h actual %h", $time, want.nvb, got.nvb);
                    fail_count = fail_count + 1;
                end
                if (got.outcome !== want.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                             got.outcome);
                    fail_count = fail_count + 1;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated expected %0d actual %0d", $time, want.sat,
                             got.sat);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Run time limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Corner pairs at the reset gravity: zero, coincident, head-on, separating, extremes.
    task automatic test_directed_pairs();
        t_pair p;
        p = '{default: '0};
        send_pair(p);
        // Coincident centers with nonzero radii.
        p.ra = 20'd1024; p.rb = 20'd1024; p.sa = 16'd4096; p.sb = 16'd4096;
        send_pair(p);
        // Head-on approach along x.
        p.pb[0] = 21'd1024; p.va[0] = 21'd2048; p.vb[0] = -21'sd2048;
        send_pair(p);
        // Same pair moving apart.
        p.va[0] = -21'sd2048; p.vb[0] = 21'd2048;
        send_pair(p);
        // Diagonal approach with offsets and a full-scale hit time.
        p.pa = rand_vec(100); p.pb = '{21'd600, 21'd500, 21'd400};
        p.oa = '{21'd10, 21'd20, 21'd30}; p.ob = rand_vec(50);
        p.va = '{21'd5000, 21'd5000, 21'd5000}; p.vb = rand_vec(100);
        p.t  = 16'hFFFF;
        send_pair(p);
        // Largest fields everywhere.
        p.pa = '1; p.va = '1; p.oa = '1; p.pb = '1; p.vb = '1; p.ob = '1;
        p.ra = '1; p.rb = '1; p.sa = '1; p.sb = '1; p.t = '1;
        send_pair(p);
        // Positive and negative component limits, pushes into saturation.
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = CMAX[COMP_BITS-1:0]; p.pb[i] = CMIN[COMP_BITS-1:0];
            p.va[i] = CMAX[COMP_BITS-1:0]; p.vb[i] = CMIN[COMP_BITS-1:0];
            p.oa[i] = CMIN[COMP_BITS-1:0]; p.ob[i] = CMAX[COMP_BITS-1:0];
        end
        send_pair(p);
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = CMAX[COMP_BITS-1:0] - 21'd10; p.pb[i] = CMAX[COMP_BITS-1:0];
            p.va[i] = CMAX[COMP_BITS-1:0]; p.vb[i] = CMIN[COMP_BITS-1:0];
            p.oa[i] = '0; p.ob[i] = '0;
        end
        p.t = 16'd0;
        send_pair(p);
        // Radius with zero scale: no contact even when centers meet.
        p = '{default: '0};
        p.ra = '1; p.rb = '1;
        send_pair(p);
        repeat (12) send_pair(noise_pair());
        drain_pipeline();
    endtask

    // Random pairs under several gravity settings, extremes included.
    task automatic test_gravity_settings();
        logic [GRV_BITS-1:0] settings[4];
        settings = '{16'd0, 16'hFFFF, GRV_BITS'($urandom()), GRAV_RESET};
        foreach (settings[k]) begin
            write_gravity(settings[k]);
            repeat (100) send_pair(mixed_pair());
            drain_pipeline();
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        steady_send = 1'b1;
        hold_req    = 1'b1;
        repeat (100) send_pair(mixed_pair());
        hold_req    = 1'b0;
        steady_send = 1'b0;
        drain_pipeline();
    endtask

    // Long random stream with stretches of full rate on both sides.
    task automatic test_random_stream();
        for (int blk = 0; blk < 15; blk++) begin
            steady_send = (blk % 5 == 2);
            steady_recv = (blk % 5 == 2) || (blk % 7 == 3);
            repeat (50) send_pair(mixed_pair());
        end
        steady_send = 1'b0;
        steady_recv = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        gravity_model = GRAV_RESET;
        hold_req      = 1'b0;
        steady_send   = 1'b0;
        steady_recv   = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_pairs();
        test_gravity_settings();
        test_backpressure();
        test_random_stream();

        drain_pipeline();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sphere_sphere_collision_response_top.f
rtl/sscr_pkg.sv
rtl/sphere_sphere_collision_response_top.sv
rtl/sscr_checker.sv
tb/tb_sphere_sphere_collision_response_top.sv
